@@ hw/rtl/dms_pkg.sv @@
package dms_pkg;

    localparam int TIMER_WIDTH = 32;

    localparam logic [7:0] CH_START = 8'h40;
    localparam logic [7:0] CH_END   = 8'h3B;
    localparam logic [7:0] CH_OPEN  = 8'h6F;
    localparam logic [7:0] CH_CLOSE = 8'h63;

    localparam logic [15:0] SAMPLE_PERIOD_RESET = 16'd500;
    localparam logic [31:0] AUTO_CLOSE_RESET    = 32'd10000;

    typedef enum logic {
        REG_SAMPLE_PERIOD = 1'b0,
        REG_AUTO_CLOSE    = 1'b1
    } t_reg_index;

    typedef enum logic [2:0] {
        ST_UNKNOWN = 3'd0,
        ST_READY   = 3'd1,
        ST_CLOSED  = 3'd2,
        ST_OPEN    = 3'd3,
        ST_OPENING = 3'd4,
        ST_CLOSING = 3'd5
    } t_gate_state;

    typedef enum logic [1:0] {
        FR_WAIT    = 2'd0,
        FR_COMMAND = 2'd1,
        FR_SKIP    = 2'd2,
        FR_END     = 2'd3
    } t_frame_pos;

endpackage

@@ hw/rtl/door_motor_sequencer.sv @@
// Gate motor sequencer.
// The input channel (i_in_valid / o_in_ready) carries one request per item:
// with i_cmd low it is a sensor sample that advances the elapsed-time counter
// by the sample period and applies the transition rules, with i_cmd high it is
// one serial byte for the '@' command ';' frame parser.
// Every request produces exactly one result on the output channel
// (o_out_valid / i_out_ready): the gate state and the two motor drives.
// The state is updated in the cycle a request is accepted, and its result is
// registered into the output queue. A new request can be accepted in every
// cycle while the queue is not full; the throughput is one request per cycle.
// Results go through a two-entry output queue. When the receiver stalls the
// queue fills, and o_in_ready drops only once both entries are occupied.
// The configuration port (i_cfg_we, i_cfg_index, i_cfg_data) writes the sample
// period and the auto-close time at any clock edge with the write enable high.
// Synchronous reset clears the queue, the parser and the pending requests,
// sets the state to unknown, and loads the register defaults of 500 ms and
// 10000 ms. The first sample after reset sets the state from the end sensors.
module door_motor_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic        i_sensor_top,
    input  logic        i_sensor_bottom,
    input  logic        i_button,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_gate_state,
    output logic        o_drive_up,
    output logic        o_drive_down
);

    localparam int TW = dms_pkg::TIMER_WIDTH;

    logic [15:0]             r_sample_period;
    logic [31:0]             r_auto_close;
    dms_pkg::t_gate_state    r_state;
    dms_pkg::t_gate_state    n_state;
    logic [TW-1:0]           r_elapsed;
    logic [TW-1:0]           n_elapsed;
    logic                    r_open_pending;
    logic                    n_open_pending;
    logic                    r_close_pending;
    logic                    n_close_pending;
    dms_pkg::t_frame_pos     r_frame_pos;
    dms_pkg::t_frame_pos     n_frame_pos;
    logic [7:0]              r_frame_cmd;
    logic [7:0]              n_frame_cmd;

    dms_pkg::t_gate_state    r_buf_state [2];
    logic                    r_wr_ptr;
    logic                    r_rd_ptr;
    logic [1:0]              r_count;

    logic                    in_accept;
    logic                    out_accept;
    logic [TW:0]             timer_sum;
    logic                    timed_out;
    dms_pkg::t_gate_state    head_state;

    assign o_in_ready  = (r_count != 2'd2);
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != 2'd0);
    assign out_accept  = o_out_valid && i_out_ready;

    assign timer_sum = {1'b0, r_elapsed} + (TW + 1)'(r_sample_period);

    always_comb begin
        n_state         = r_state;
        n_elapsed       = r_elapsed;
        n_open_pending  = r_open_pending;
        n_close_pending = r_close_pending;
        n_frame_pos     = r_frame_pos;
        n_frame_cmd     = r_frame_cmd;
        timed_out       = 1'b0;
        if (i_cmd) begin
            case (r_frame_pos)
                dms_pkg::FR_WAIT: begin
                    if (i_rx_byte == dms_pkg::CH_START) begin
                        n_frame_pos = dms_pkg::FR_COMMAND;
                    end
                end
                dms_pkg::FR_COMMAND: begin
                    n_frame_cmd = i_rx_byte;
                    n_frame_pos = dms_pkg::FR_SKIP;
                end
                dms_pkg::FR_SKIP: begin
                    n_frame_pos = dms_pkg::FR_END;
                end
                default: begin
                    if (i_rx_byte == dms_pkg::CH_END) begin
                        if (r_frame_cmd == dms_pkg::CH_OPEN) begin
                            n_open_pending = 1'b1;
                        end else if (r_frame_cmd == dms_pkg::CH_CLOSE) begin
                            n_close_pending = 1'b1;
                        end
                    end
                    n_frame_pos = dms_pkg::FR_WAIT;
                end
            endcase
        end else if (r_state == dms_pkg::ST_UNKNOWN) begin
            if (i_sensor_bottom) begin
                n_state = dms_pkg::ST_CLOSED;
            end else if (i_sensor_top) begin
                n_state = dms_pkg::ST_OPEN;
            end else begin
                n_state = dms_pkg::ST_READY;
            end
            n_elapsed = '0;
        end else begin
            n_elapsed = timer_sum[TW] ? {TW{1'b1}} : timer_sum[TW-1:0];
            if (n_state == dms_pkg::ST_CLOSED && (i_button || n_open_pending)) begin
                n_state        = dms_pkg::ST_OPENING;
                n_open_pending = 1'b0;
            end
            if (n_state == dms_pkg::ST_OPENING && i_sensor_top) begin
                n_state   = dms_pkg::ST_OPEN;
                n_elapsed = '0;
            end
            timed_out = (64'(n_elapsed) >= 64'(r_auto_close));
            if (n_state == dms_pkg::ST_OPEN && (i_button || timed_out || n_close_pending)) begin
                n_state         = dms_pkg::ST_CLOSING;
                n_close_pending = 1'b0;
            end
            if (n_state == dms_pkg::ST_CLOSING && i_sensor_bottom) begin
                n_state = dms_pkg::ST_CLOSED;
            end
            if (n_state == dms_pkg::ST_READY && (i_button || n_open_pending)) begin
                n_state        = dms_pkg::ST_OPENING;
                n_open_pending = 1'b0;
            end
            if (n_state == dms_pkg::ST_READY && (timed_out || n_close_pending)) begin
                n_state         = dms_pkg::ST_CLOSING;
                n_close_pending = 1'b0;
            end
        end
    end

    always_comb begin
        head_state   = r_buf_state[r_rd_ptr];
        o_gate_state = head_state;
        o_drive_up   = (head_state == dms_pkg::ST_OPENING);
        o_drive_down = (head_state == dms_pkg::ST_CLOSING);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period <= dms_pkg::SAMPLE_PERIOD_RESET;
            r_auto_close    <= dms_pkg::AUTO_CLOSE_RESET;
        end else if (i_cfg_we) begin
            case (dms_pkg::t_reg_index'(i_cfg_index))
                dms_pkg::REG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data[15:0];
                dms_pkg::REG_AUTO_CLOSE:    r_auto_close    <= i_cfg_data;
                default:                    r_auto_close    <= r_auto_close;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= dms_pkg::ST_UNKNOWN;
            r_elapsed       <= '0;
            r_open_pending  <= 1'b0;
            r_close_pending <= 1'b0;
            r_frame_pos     <= dms_pkg::FR_WAIT;
            r_frame_cmd     <= '0;
        end else if (in_accept) begin
            r_state         <= n_state;
            r_elapsed       <= n_elapsed;
            r_open_pending  <= n_open_pending;
            r_close_pending <= n_close_pending;
            r_frame_pos     <= n_frame_pos;
            r_frame_cmd     <= n_frame_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_buf_state[r_wr_ptr] <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (in_accept) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (out_accept) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({in_accept, out_accept})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("Output queue count out of range.");

    a_drive_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_drive_up && o_drive_down))
        else $error("Both motor drives active.");

    a_first_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_cmd) |=> r_state != dms_pkg::ST_UNKNOWN)
        else $error("State still unknown after a sample.");

    a_byte_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_cmd) |=> r_state == $past(r_state))
        else $error("Serial byte changed the gate state.");

endmodule
